@@ rtl/core/ctt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the config text tokenizer
// Token kinds, error kinds, scan modes and the token record.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int unsigned DEF_MAX_SOURCE_BYTES = 65536;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_STRING, M_STRING_ESC, M_DIRECTIVE,
        M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_SUFFIX, M_IDENT
    } scan_mode_t;

    localparam logic [4:0] K_EOF       = 5'd0;
    localparam logic [4:0] K_DOT       = 5'd6;
    localparam logic [4:0] K_COMMENT   = 5'd9;
    localparam logic [4:0] K_STRING    = 5'd10;
    localparam logic [4:0] K_DIRECTIVE = 5'd11;
    localparam logic [4:0] K_NUMBER    = 5'd12;
    localparam logic [4:0] K_IDENT     = 5'd13;
    localparam logic [4:0] K_TRUE      = 5'd14;
    localparam logic [4:0] K_FALSE     = 5'd15;
    localparam logic [4:0] K_NULL      = 5'd16;
    localparam logic [4:0] K_ERROR     = 5'd17;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
    localparam logic [39:0] WORD_NULL  = 40'h006e756c6c;
    localparam logic [39:0] WORD_FALSE = 40'h66616c7365;

    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  err;
        logic [15:0] start;
        logic [16:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } token_t;

    // up to three tokens produced by one byte
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } token_group_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

endpackage : ctt_pkg
`default_nettype wire

@@ rtl/core/config_text_tokenizer_unit.sv @@
// a token group is written into the group queue when its byte is accepted; its words are offered from the queue head
// throughput: one byte per cycle while the group queue is not full; a group of k tokens
// leaves as k output words, absorbed by a four-entry group queue between scanner and emitter
// reset: rst_n asynchronous active low; position counts return to line 1 col 1
// end_of_text also returns the scanner to its reset state
`default_nettype none
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit: streaming tokenizer top level
// Byte scanner, group queue and token emitter.
// ----------------------------------------------------------------------------
module config_text_tokenizer_unit
    import ctt_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_BYTES = DEF_MAX_SOURCE_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       token_kind,
    output logic [1:0]       error_kind,
    output logic [15:0]      start_offset,
    output logic [16:0]      lexeme_length,
    output logic [15:0]      line,
    output logic [15:0]      column,
    output logic             last
);

    token_group_t grp, head;
    token_t       tok;
    logic         full, empty, pop, fire;

    assign in_ready = !full;
    assign fire = in_valid && in_ready;

    ctt_front #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .ch(ch), .end_of_text(end_of_text),
        .in_fire(fire), .group_out(grp)
    );

    ctt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(fire && grp.count != 2'd0),
        .push_data(grp), .full(full), .pop(pop), .empty(empty), .head(head)
    );

    ctt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
        .out_valid(out_valid), .out_ready(out_ready), .out_tok(tok)
    );

    assign token_kind = tok.kind;
    assign error_kind = tok.err;
    assign start_offset = tok.start;
    assign lexeme_length = tok.len;
    assign line = tok.line;
    assign column = tok.col;
    assign last = tok.last;

endmodule : config_text_tokenizer_unit
`default_nettype wire

@@ rtl/core/ctt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_front: scanner front end
// Accepts one byte per cycle while in_fire is high, tracks position and scan mode, and builds the
// group of tokens that the byte closes or forms.
// ----------------------------------------------------------------------------
module ctt_front
    import ctt_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_BYTES = DEF_MAX_SOURCE_BYTES,
    localparam int unsigned OW = $clog2(MAX_SOURCE_BYTES + 1)
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   ch,
    input  wire logic         end_of_text,
    input  wire logic         in_fire,
    output token_group_t      group_out
);

    localparam logic [OW-1:0] MAX_OFF = OW'(MAX_SOURCE_BYTES);

    scan_mode_t   mode_reg, mode_next;
    logic         qsingle_reg, qsingle_next;
    logic [OW-1:0] off_reg, off_next, tstart_reg, tstart_next;
    logic [15:0]  tline_reg, tline_next, tcol_reg, tcol_next;
    logic [15:0]  line_reg, line_next, col_reg, col_next;
    logic [1:0]   suf_reg, suf_next;
    logic [39:0]  kw_reg, kw_next;

    token_t       tk [3];
    logic [1:0]   n;
    logic [OW-1:0] off_inc, off_m1;
    logic [15:0]  dot_col;
    logic         restart;
    logic         is_alnum_c;
    logic [7:0]   quote;
    logic [3:0]   punct;

    function automatic logic [16:0] span(input logic [OW-1:0] e, input logic [OW-1:0] b);
        return (e >= b) ? 17'(e - b) : 17'd0;
    endfunction

    function automatic token_t mk(input logic [4:0] k, input logic [1:0] er,
                                  input logic [OW-1:0] s, input logic [16:0] l,
                                  input logic [15:0] ln, input logic [15:0] cl);
        token_t t;
        t.kind = k;
        t.err = er;
        t.start = 16'(s);
        t.len = l;
        t.line = ln;
        t.col = cl;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic logic [4:0] word_kind(input logic [16:0] l, input logic [39:0] w);
        if (l == 17'd4 && w == WORD_TRUE)
            return K_TRUE;
        else if (l == 17'd5 && w == WORD_FALSE)
            return K_FALSE;
        else if (l == 17'd4 && w == WORD_NULL)
            return K_NULL;
        return K_IDENT;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            qsingle_reg <= 1'b0;
            off_reg     <= '0;
            tstart_reg  <= '0;
            tline_reg   <= 16'd1;
            tcol_reg    <= 16'd1;
            line_reg    <= 16'd1;
            col_reg     <= 16'd1;
            suf_reg     <= '0;
            kw_reg      <= '0;
        end
        else if (in_fire)
        begin
            mode_reg    <= mode_next;
            qsingle_reg <= qsingle_next;
            off_reg     <= off_next;
            tstart_reg  <= tstart_next;
            tline_reg   <= tline_next;
            tcol_reg    <= tcol_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            suf_reg     <= suf_next;
            kw_reg      <= kw_next;
        end
    end

    always_comb
    begin
        off_inc = (off_reg < MAX_OFF) ? off_reg + OW'(1) : MAX_OFF;
        off_m1 = (off_reg >= OW'(1)) ? off_reg - OW'(1) : '0;
        dot_col = (col_reg < 16'hffff) ? col_reg - 16'd1 : 16'hffff;
        is_alnum_c = is_letter(ch) || is_digit(ch);
        quote = qsingle_reg ? 8'h27 : 8'h22;
        mode_next = mode_reg;
        qsingle_next = qsingle_reg;
        off_next = off_inc;
        tstart_next = tstart_reg;
        tline_next = tline_reg;
        tcol_next = tcol_reg;
        line_next = line_reg;
        col_next = col_reg;
        suf_next = suf_reg;
        kw_next = kw_reg;
        restart = 1'b0;
        n = 2'd0;
        punct = 4'd0;
        for (int i = 0; i < 3; i++)
            tk[i] = '0;

        if (end_of_text)
        begin
            unique case (mode_reg)
                M_COMMENT:
                begin
                    tk[0] = mk(K_COMMENT, E_NONE, tstart_reg, span(off_reg, tstart_reg),
                               tline_reg, tcol_reg);
                    n = 2'd1;
                end
                M_STRING, M_STRING_ESC:
                begin
                    tk[0] = mk(K_ERROR, E_UNTERM, tstart_reg, span(off_reg, tstart_reg),
                               tline_reg, tcol_reg);
                    n = 2'd1;
                end
                M_DIRECTIVE:
                begin
                    tk[0] = mk(K_DIRECTIVE, E_NONE, tstart_reg, span(off_reg, tstart_reg),
                               tline_reg, tcol_reg);
                    n = 2'd1;
                end
                M_NUM_INT, M_NUM_FRAC, M_NUM_SUFFIX:
                begin
                    tk[0] = mk(K_NUMBER, E_NONE, tstart_reg, span(off_reg, tstart_reg),
                               tline_reg, tcol_reg);
                    n = 2'd1;
                end
                M_NUM_DOT:
                begin
                    tk[0] = mk(K_NUMBER, E_NONE, tstart_reg, span(off_m1, tstart_reg),
                               tline_reg, tcol_reg);
                    tk[1] = mk(K_DOT, E_NONE, off_m1, 17'd1, line_reg, dot_col);
                    n = 2'd2;
                end
                M_IDENT:
                begin
                    tk[0] = mk(word_kind(span(off_reg, tstart_reg), kw_reg), E_NONE,
                               tstart_reg, span(off_reg, tstart_reg), tline_reg, tcol_reg);
                    n = 2'd1;
                end
                default: ;
            endcase
            tk[n] = mk(K_EOF, E_NONE, off_reg, 17'd0, line_reg, col_reg);
            n = n + 2'd1;
            mode_next = M_IDLE;
            qsingle_next = 1'b0;
            off_next = '0;
            tstart_next = '0;
            tline_next = 16'd1;
            tcol_next = 16'd1;
            line_next = 16'd1;
            col_next = 16'd1;
            suf_next = '0;
            kw_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_COMMENT:
                    if (ch == 8'h0a)
                    begin
                        tk[0] = mk(K_COMMENT, E_NONE, tstart_reg,
                                   span(off_reg, tstart_reg), tline_reg, tcol_reg);
                        n = 2'd1;
                        restart = 1'b1;
                    end
                M_STRING:
                    if (ch == quote)
                    begin
                        tk[0] = mk(K_STRING, E_NONE, tstart_reg,
                                   span(off_reg, tstart_reg), tline_reg, tcol_reg);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (ch == 8'h5c)
                        mode_next = M_STRING_ESC;
                M_STRING_ESC:
                    if (ch != 8'h5c)
                        mode_next = M_STRING;
                M_DIRECTIVE:
                    if (!is_alnum_c)
                    begin
                        tk[0] = mk(K_DIRECTIVE, E_NONE, tstart_reg,
                                   span(off_reg, tstart_reg), tline_reg, tcol_reg);
                        n = 2'd1;
                        restart = 1'b1;
                    end
                M_NUM_INT, M_NUM_FRAC:
                    if (is_digit(ch))
                        mode_next = mode_reg;
                    else if (ch == 8'h2e && mode_reg == M_NUM_INT)
                        mode_next = M_NUM_DOT;
                    else if (is_letter(ch))
                    begin
                        mode_next = M_NUM_SUFFIX;
                        suf_next = 2'd1;
                    end
                    else
                    begin
                        tk[0] = mk(K_NUMBER, E_NONE, tstart_reg,
                                   span(off_reg, tstart_reg), tline_reg, tcol_reg);
                        n = 2'd1;
                        restart = 1'b1;
                    end
                M_NUM_DOT:
                    if (is_digit(ch))
                        mode_next = M_NUM_FRAC;
                    else
                    begin
                        tk[0] = mk(K_NUMBER, E_NONE, tstart_reg,
                                   span(off_m1, tstart_reg), tline_reg, tcol_reg);
                        tk[1] = mk(K_DOT, E_NONE, off_m1, 17'd1, line_reg, dot_col);
                        n = 2'd2;
                        restart = 1'b1;
                    end
                M_NUM_SUFFIX:
                    if (is_letter(ch) && suf_reg < 2'd3)
                        suf_next = suf_reg + 2'd1;
                    else
                    begin
                        tk[0] = mk(K_NUMBER, E_NONE, tstart_reg,
                                   span(off_reg, tstart_reg), tline_reg, tcol_reg);
                        n = 2'd1;
                        restart = 1'b1;
                    end
                M_IDENT:
                    if (is_alnum_c)
                        kw_next = {kw_reg[31:0], ch};
                    else
                    begin
                        tk[0] = mk(word_kind(span(off_reg, tstart_reg), kw_reg), E_NONE,
                                   tstart_reg, span(off_reg, tstart_reg), tline_reg,
                                   tcol_reg);
                        n = 2'd1;
                        restart = 1'b1;
                    end
                default:
                    restart = 1'b1;
            endcase

            if (restart)
            begin
                mode_next = M_IDLE;
                tstart_next = off_reg;
                tline_next = line_reg;
                tcol_next = col_reg;
                case (ch)
                    8'h7b: punct = 4'd1;
                    8'h7d: punct = 4'd2;
                    8'h5b: punct = 4'd3;
                    8'h5d: punct = 4'd4;
                    8'h2c: punct = 4'd5;
                    8'h2e: punct = 4'd6;
                    8'h3b: punct = 4'd7;
                    8'h3d: punct = 4'd8;
                    default: punct = 4'd0;
                endcase
                if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0d || ch == 8'h0a)
                    mode_next = M_IDLE;
                else if (ch == 8'h23)
                    mode_next = M_COMMENT;
                else if (ch == 8'h22 || ch == 8'h27)
                begin
                    mode_next = M_STRING;
                    qsingle_next = (ch == 8'h27);
                    tstart_next = off_inc;
                end
                else if (ch == 8'h40)
                begin
                    mode_next = M_DIRECTIVE;
                    tstart_next = off_inc;
                    tcol_next = sat_inc16(col_reg);
                end
                else if (punct != 4'd0)
                begin
                    tk[n] = mk({1'b0, punct}, E_NONE, off_reg, 17'd1, line_reg, col_reg);
                    n = n + 2'd1;
                end
                else if (is_digit(ch))
                    mode_next = M_NUM_INT;
                else if (is_letter(ch))
                begin
                    mode_next = M_IDENT;
                    kw_next = {32'd0, ch};
                end
                else
                begin
                    tk[n] = mk(K_ERROR, E_UNEXPECTED, off_reg, 17'd1, line_reg, col_reg);
                    n = n + 2'd1;
                end
            end

            if (ch == 8'h0a)
            begin
                line_next = sat_inc16(line_reg);
                col_next = 16'd1;
            end
            else
                col_next = sat_inc16(col_reg);
        end

        if (n != 2'd0)
            tk[n - 2'd1].last = 1'b1;
        group_out.count = n;
        group_out.t0 = tk[0];
        group_out.t1 = tk[1];
        group_out.t2 = tk[2];
    end

endmodule : ctt_front
`default_nettype wire

@@ rtl/core/ctt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_queue: token group queue
// Short queue of token groups between scanner and emitter.
// ----------------------------------------------------------------------------
module ctt_queue
    import ctt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  token_group_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        empty,
    output token_group_t head
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    token_group_t     mem [QUEUE_DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + AW'(1);
            if (pop)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule : ctt_queue
`default_nettype wire

@@ rtl/core/ctt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_back: token emitter
// Takes token groups from the queue and sends their tokens one per word.
// ----------------------------------------------------------------------------
module ctt_back
    import ctt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  token_group_t q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output token_t      out_tok
);

    logic [1:0] idx_reg, idx_next;
    token_t     sel;

    always_comb
    begin
        case (idx_reg)
            2'd0: sel = q_head.t0;
            2'd1: sel = q_head.t1;
            default: sel = q_head.t2;
        endcase
    end

    assign out_valid = !q_empty;
    assign out_tok = sel;

    always_comb
    begin
        idx_next = idx_reg;
        q_pop = 1'b0;
        if (out_valid && out_ready)
        begin
            if (idx_reg + 2'd1 >= q_head.count)
            begin
                q_pop = 1'b1;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule : ctt_back
`default_nettype wire

@@ rtl/core/ctt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_checker: port checker
// Checks handshake and token field rules seen at the top level ports.
// ----------------------------------------------------------------------------
module ctt_checker
    import ctt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  token_kind,
    input wire logic [1:0]  error_kind,
    input wire logic [16:0] lexeme_length,
    input wire logic [15:0] line,
    input wire logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("output word dropped or changed while stalled");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last && lexeme_length == 17'd0)
        else $error("eof word not last or nonzero length");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_ERROR |-> error_kind == E_NONE)
        else $error("error kind on non-error token");

    a_line_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line != 16'd0)
        else $error("line zero");

endmodule : ctt_checker

bind config_text_tokenizer_unit ctt_checker u_ctt_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .error_kind(error_kind),
    .lexeme_length(lexeme_length), .line(line), .last(last)
);
`default_nettype wire
